// ===== src/alarm_report_frame_parser_assert.svh =====
// Assertion macros for the alarm report frame parser.
`ifndef ALARM_REPORT_FRAME_PARSER_ASSERT_SVH
`define ALARM_REPORT_FRAME_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define ARFP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ARFP_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");
`else
`define ARFP_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ARFP_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== src/arfp_pkg.sv =====
// Shared constants and types for the alarm report frame parser.
`timescale 1ns / 1ps
`default_nettype none
package arfp_pkg;

   localparam int ARFP_MAX_FRAME   = 1024;
   localparam int ARFP_QUEUE_DEPTH = 4;

   // patterns as they sit in the byte window, newest byte lowest
   localparam logic [47:0] START_PAT = 48'h1B_40_1C_2E_0D_0A;
   localparam logic [39:0] END_PAT   = 40'h0A_0A_1B_69_01;
   localparam logic [31:0] FIRE_PAT  = 32'hBB_F0_BE_AF;
   localparam logic [31:0] FAULT_PAT = 32'hB9_CA_D5_CF;
   localparam logic [31:0] CLEAR_PAT = 32'hCF_FB_B3_FD;
   localparam logic [63:0] ADDR_PAT  = 64'h61_64_64_72_65_73_73_3A;
   localparam logic [7:0]  ASCII_ZERO = 8'h30;
   localparam logic [7:0]  ASCII_NINE = 8'h39;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_FIRE    = 2'd1,
      KIND_FAULT   = 2'd2,
      KIND_CLEARED = 2'd3
   } event_kind_type;

   // one classified byte handed from front to back
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       start_hit;
      logic       end_hit;
      logic       addr_hit;
      logic       fire_hit;
      logic       fault_hit;
      logic       clear_hit;
   } token_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

// ===== src/arfp_front.sv =====
// Front end: byte window and pattern classification of each received byte.
`timescale 1ns / 1ps
`default_nettype none
module arfp_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire [7:0]            req_rx_byte,
   input  wire                  queue_full,
   output logic                 push,
   output arfp_pkg::token_type  push_token
);
   import arfp_pkg::*;

   logic [63:0] window_ff;
   logic [63:0] window_in;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;
   assign window_in = {window_ff[55:0], req_rx_byte};

   always_comb begin
      push_token.rx_byte   = req_rx_byte;
      push_token.start_hit = (window_in[47:0] == START_PAT);
      push_token.end_hit   = (window_in[39:0] == END_PAT);
      push_token.addr_hit  = (window_in == ADDR_PAT);
      push_token.fire_hit  = (window_in[31:0] == FIRE_PAT);
      push_token.fault_hit = (window_in[31:0] == FAULT_PAT);
      push_token.clear_hit = (window_in[31:0] == CLEAR_PAT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (push) begin
         window_ff <= window_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/arfp_queue.sv =====
// Short queue of classified bytes between front and back.
`timescale 1ns / 1ps
`default_nettype none
module arfp_queue (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         push,
   input  arfp_pkg::token_type         push_token,
   input  wire                         pop,
   output arfp_pkg::token_type         head_token,
   output arfp_pkg::queue_status_type  status
);
   import arfp_pkg::*;

   localparam int PTR_W = $clog2(ARFP_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ARFP_QUEUE_DEPTH + 1);

   token_type          slot_ff [ARFP_QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push;
   logic               do_pop;

   assign status.full  = (count_ff == CNT_W'(ARFP_QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_token   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule
`default_nettype wire

// ===== src/arfp_back.sv =====
// Back end: frame tracking, keyword flags, address digits and result register.
`timescale 1ns / 1ps
`default_nettype none
module arfp_back #(
   parameter int MAX_FRAME = arfp_pkg::ARFP_MAX_FRAME
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  queue_empty,
   input  arfp_pkg::token_type  head_token,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [1:0]           rsp_event_kind,
   output logic [9:0]           rsp_part_id,
   output logic                 rsp_id_valid
);
   import arfp_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME);
   localparam logic [CNT_W-1:0] CNT_WRAP = CNT_W'(MAX_FRAME - 2);

   typedef enum logic {
      HUNT,
      FRAME
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             fire_ff, fire_in;
   logic             fault_ff, fault_in;
   logic             cleared_ff, cleared_in;
   logic [2:0]       phase_ff, phase_in;
   logic [9:0]       accum_ff, accum_in;
   logic             digits_ok_ff, digits_ok_in;
   logic             out_valid_ff, out_valid_in;
   event_kind_type   out_kind_ff, out_kind_in;
   logic [9:0]       out_id_ff, out_id_in;
   logic             out_id_valid_ff, out_id_valid_in;

   logic [CNT_W-1:0] base_count;
   logic             id_good;
   event_kind_type   kind;

   assign pop            = !queue_empty && (!out_valid_ff || rsp_ready);
   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_kind_ff;
   assign rsp_part_id    = out_id_ff;
   assign rsp_id_valid   = out_id_valid_ff;

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      fire_in         = fire_ff;
      fault_in        = fault_ff;
      cleared_in      = cleared_ff;
      phase_in        = phase_ff;
      accum_in        = accum_ff;
      digits_ok_in    = digits_ok_ff;
      out_valid_in    = out_valid_ff && !rsp_ready;
      out_kind_in     = out_kind_ff;
      out_id_in       = out_id_ff;
      out_id_valid_in = out_id_valid_ff;
      base_count      = count_ff;
      kind            = KIND_NONE;
      id_good         = 1'b0;

      if (pop) begin
         case (state_ff)
            HUNT: begin
               if (head_token.start_hit) begin
                  state_in     = FRAME;
                  count_in     = CNT_W'(6);
                  fire_in      = 1'b0;
                  fault_in     = 1'b0;
                  cleared_in   = 1'b0;
                  phase_in     = '0;
                  accum_in     = '0;
                  digits_ok_in = 1'b0;
               end
            end
            FRAME: begin
               // drop everything gathered once the frame runs too long
               if (count_ff >= CNT_WRAP) begin
                  base_count   = '0;
                  fire_in      = 1'b0;
                  fault_in     = 1'b0;
                  cleared_in   = 1'b0;
                  phase_in     = '0;
                  accum_in     = '0;
                  digits_ok_in = 1'b0;
               end
               count_in = base_count + CNT_W'(1);

               if (phase_in inside {[3'd2:3'd4]}) begin
                  if (head_token.rx_byte inside {[ASCII_ZERO:ASCII_NINE]}) begin
                     accum_in = (accum_in << 3) + (accum_in << 1)
                              + {6'd0, head_token.rx_byte[3:0]};
                  end else begin
                     digits_ok_in = 1'b0;
                  end
               end
               if (phase_in inside {[3'd1:3'd4]}) begin
                  phase_in = phase_in + 3'd1;
               end else if (phase_in == 3'd0 && count_in >= CNT_W'(8)
                            && head_token.addr_hit) begin
                  phase_in     = 3'd1;
                  accum_in     = '0;
                  digits_ok_in = 1'b1;
               end

               if (count_in >= CNT_W'(4)) begin
                  fire_in    = fire_in || head_token.fire_hit;
                  fault_in   = fault_in || head_token.fault_hit;
                  cleared_in = cleared_in || head_token.clear_hit;
               end

               if (count_in >= CNT_W'(6) && head_token.end_hit) begin
                  if (fire_in) begin
                     kind = KIND_FIRE;
                  end else if (fault_in && cleared_in) begin
                     kind = KIND_CLEARED;
                  end else if (fault_in) begin
                     kind = KIND_FAULT;
                  end else begin
                     kind = KIND_NONE;
                  end
                  id_good = (kind != KIND_NONE) && (phase_in == 3'd5) && digits_ok_in;

                  out_valid_in    = 1'b1;
                  out_kind_in     = kind;
                  out_id_in       = id_good ? accum_in : 10'd0;
                  out_id_valid_in = id_good;

                  state_in     = HUNT;
                  count_in     = '0;
                  fire_in      = 1'b0;
                  fault_in     = 1'b0;
                  cleared_in   = 1'b0;
                  phase_in     = '0;
                  accum_in     = '0;
                  digits_ok_in = 1'b0;
               end
            end
            default: begin
               state_in = HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= HUNT;
         count_ff        <= '0;
         fire_ff         <= 1'b0;
         fault_ff        <= 1'b0;
         cleared_ff      <= 1'b0;
         phase_ff        <= '0;
         accum_ff        <= '0;
         digits_ok_ff    <= 1'b0;
         out_valid_ff    <= 1'b0;
         out_kind_ff     <= KIND_NONE;
         out_id_ff       <= '0;
         out_id_valid_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         fire_ff         <= fire_in;
         fault_ff        <= fault_in;
         cleared_ff      <= cleared_in;
         phase_ff        <= phase_in;
         accum_ff        <= accum_in;
         digits_ok_ff    <= digits_ok_in;
         out_valid_ff    <= out_valid_in;
         out_kind_ff     <= out_kind_in;
         out_id_ff       <= out_id_in;
         out_id_valid_ff <= out_id_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/alarm_report_frame_parser.sv =====
// Alarm report frame parser: takes one byte per clock while the queue is not
// full and gives one result per closed frame. The front end shifts each accepted
// byte into an eight-byte window and matches the start, end, keyword and address
// patterns in the same cycle; a four-entry queue carries the classified bytes to
// the back end, which updates the frame state for each byte and loads the result
// register. The back end takes one byte per clock while the result register is
// free or being taken. A frame's final end byte passes through the queue and
// then the result register before its result is offered. While a result
// waits the back end holds, and the queue keeps taking bytes until it is full.
`timescale 1ns / 1ps
`default_nettype none
module alarm_report_frame_parser #(
   parameter int MAX_FRAME = arfp_pkg::ARFP_MAX_FRAME
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire [7:0]   req_rx_byte,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [9:0]  rsp_part_id,
   output logic        rsp_id_valid
);
   import arfp_pkg::*;

   logic             push;
   logic             pop;
   token_type        push_token;
   token_type        head_token;
   queue_status_type queue_status;
   logic             rsp_good_id;
   logic             rsp_no_id;

   arfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_rx_byte(req_rx_byte),
      .queue_full (queue_status.full),
      .push       (push),
      .push_token (push_token)
   );

   arfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .head_token (head_token),
      .status     (queue_status)
   );

   arfp_back #(
      .MAX_FRAME(MAX_FRAME)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_status.empty),
      .head_token    (head_token),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_kind(rsp_event_kind),
      .rsp_part_id   (rsp_part_id),
      .rsp_id_valid  (rsp_id_valid)
   );

   assign rsp_good_id = rsp_valid && rsp_id_valid;
   assign rsp_no_id   = rsp_valid && !rsp_id_valid;

`include "alarm_report_frame_parser_assert.svh"

   `ARFP_ASSERT_NEVER(a_queue_full_and_empty, clock, reset, queue_status.full && queue_status.empty)
   `ARFP_ASSERT_IMPLIES(a_id_needs_event, clock, reset, rsp_good_id, rsp_event_kind != KIND_NONE)
   `ARFP_ASSERT_IMPLIES(a_bad_id_is_zero, clock, reset, rsp_no_id, rsp_part_id == 10'd0)
   `ARFP_ASSERT_IMPLIES(a_good_id_in_range, clock, reset, rsp_good_id, rsp_part_id <= 10'd999)

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the alarm report frame parser: directed frames, then random frames.
`timescale 1ns / 1ps
module tb_top;
   import arfp_pkg::*;

   localparam int FRAME_LIMIT = ARFP_MAX_FRAME;
   localparam int NUM_CASES   = 18;
   localparam int TAIL_CYCLES = 8;
   localparam int RUN_LIMIT   = 3_000_000;

   typedef struct packed {
      event_kind_type kind;
      logic [9:0]     part_id;
      logic           id_valid;
   } alarm_report_type;

   typedef struct packed {
      int             pad;       // zero bytes right after the start symbol
      int             len;
      logic [255:0]   body;      // last byte lowest
      logic           framed;    // wrap body in start and end symbols
      logic           typed;     // report below is known in advance
      event_kind_type kind;
      logic [9:0]     part_id;
      logic           id_valid;
   } frame_case_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_event_kind;
   logic [9:0] rsp_part_id;
   logic       rsp_id_valid;

   int send_idle_pct = 8;
   int recv_idle_pct = 49;
   int mismatches    = 0;
   int framed_items  = 0;
   int frames_closed = 0;
   int reports_seen  = 0;

   alarm_report_type pending_reports[$];
   alarm_report_type got_report;
   alarm_report_type want_report;
   frame_case_type   cases [0:NUM_CASES-1];

   // frame tracker state
   logic        frm_open;
   logic [63:0] win_bytes;
   int          frm_len;
   logic        saw_fire;
   logic        saw_fault;
   logic        saw_cleared;
   int          addr_stage;
   int          addr_value;
   logic        addr_digits_ok;

   alarm_report_frame_parser dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_part_id    (rsp_part_id),
      .rsp_id_valid   (rsp_id_valid)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch: %s (t=%0t)", what, $time);
      mismatches++;
   endtask

   task automatic drop_frame_data();
      frm_len        = 0;
      saw_fire       = 1'b0;
      saw_fault      = 1'b0;
      saw_cleared    = 1'b0;
      addr_stage     = 0;
      addr_value     = 0;
      addr_digits_ok = 1'b0;
   endtask

   // Advance the frame tracker by one byte; queue a report when a frame closes.
   task automatic track_frame_byte(input logic [7:0] b);
      alarm_report_type rep;
      win_bytes = {win_bytes[55:0], b};
      if (!frm_open) begin
         if (win_bytes[47:0] == START_PAT) begin
            drop_frame_data();
            frm_open = 1'b1;
            frm_len  = 6;
            framed_items++;
         end
      end else begin
         framed_items++;
         if (frm_len >= FRAME_LIMIT - 2)
            drop_frame_data();
         frm_len++;
         if (addr_stage >= 2 && addr_stage <= 4) begin
            if (b >= ASCII_ZERO && b <= ASCII_NINE)
               addr_value = addr_value * 10 + int'(b - ASCII_ZERO);
            else
               addr_digits_ok = 1'b0;
         end
         if (addr_stage >= 1 && addr_stage <= 4)
            addr_stage++;
         if (addr_stage == 0 && frm_len >= 8 && win_bytes == ADDR_PAT) begin
            addr_stage     = 1;
            addr_value     = 0;
            addr_digits_ok = 1'b1;
         end
         if (frm_len >= 4) begin
            if (win_bytes[31:0] == FIRE_PAT)  saw_fire    = 1'b1;
            if (win_bytes[31:0] == FAULT_PAT) saw_fault   = 1'b1;
            if (win_bytes[31:0] == CLEAR_PAT) saw_cleared = 1'b1;
         end
         if (frm_len >= 6 && win_bytes[39:0] == END_PAT) begin
            if (saw_fire)
               rep.kind = KIND_FIRE;
            else if (saw_fault && saw_cleared)
               rep.kind = KIND_CLEARED;
            else if (saw_fault)
               rep.kind = KIND_FAULT;
            else
               rep.kind = KIND_NONE;
            rep.id_valid = (rep.kind != KIND_NONE) && addr_stage == 5 && addr_digits_ok;
            rep.part_id  = rep.id_valid ? 10'(addr_value) : 10'd0;
            pending_reports = {pending_reports, rep};
            frames_closed++;
            frm_open = 1'b0;
            drop_frame_data();
         end
      end
   endtask

   // compare outgoing reports, then track incoming bytes
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got_report = '{event_kind_type'(rsp_event_kind), rsp_part_id, rsp_id_valid};
            reports_seen++;
            if (pending_reports.size() == 0) begin
               report_mismatch("report with nothing pending");
            end else begin
               want_report = pending_reports.pop_front();
               if (rsp_event_kind !== want_report.kind)
                  report_mismatch($sformatf("event_kind %0d, want %0d",
                                            rsp_event_kind, want_report.kind));
               if (rsp_part_id !== want_report.part_id)
                  report_mismatch($sformatf("part_id %0d, want %0d",
                                            rsp_part_id, want_report.part_id));
               if (rsp_id_valid !== want_report.id_valid)
                  report_mismatch($sformatf("id_valid %0b, want %0b",
                                            rsp_id_valid, want_report.id_valid));
            end
         end
         if (req_valid && req_ready)
            track_frame_byte(req_rx_byte);
      end
   end

   always @(posedge clock)
      rsp_ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // send the low n bytes of sym, first byte highest
   task automatic send_symbol(input logic [63:0] sym, input int n);
      for (int k = n - 1; k >= 0; k--)
         send_byte(sym[8*k +: 8]);
   endtask

   task automatic wait_for_reports();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
   endtask

   initial begin
      #RUN_LIMIT;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int seen_before;
      int nseg;
      int long_left;
      int cut;

      frm_open  = 1'b0;
      win_bytes = '0;
      drop_frame_data();

      cases[0]  = '{0, 16, {FIRE_PAT, ADDR_PAT, 8'h20, "123"}, 1'b1, 1'b1,
                    KIND_FIRE, 10'd123, 1'b1};
      cases[1]  = '{0, 20, {FAULT_PAT, CLEAR_PAT, ADDR_PAT, 8'hFF, "999"}, 1'b1, 1'b1,
                    KIND_CLEARED, 10'd999, 1'b1};
      cases[2]  = '{0, 16, {ADDR_PAT, 8'h00, "000", FAULT_PAT}, 1'b1, 1'b1,
                    KIND_FAULT, 10'd0, 1'b1};
      cases[3]  = '{0, 12, {CLEAR_PAT, FAULT_PAT, FIRE_PAT}, 1'b1, 1'b1,
                    KIND_FIRE, 10'd0, 1'b0};
      cases[4]  = '{0, 12, {ADDR_PAT, 8'h20, "555"}, 1'b1, 1'b1,
                    KIND_NONE, 10'd0, 1'b0};
      // digit bytes just above nine and just below zero
      cases[5]  = '{0, 16, {FAULT_PAT, ADDR_PAT, 8'h20, "1:3"}, 1'b1, 1'b1,
                    KIND_FAULT, 10'd0, 1'b0};
      cases[6]  = '{0, 16, {FAULT_PAT, ADDR_PAT, 8'h20, "/23"}, 1'b1, 1'b1,
                    KIND_FAULT, 10'd0, 1'b0};
      cases[7]  = '{0, 4, {CLEAR_PAT}, 1'b1, 1'b1, KIND_NONE, 10'd0, 1'b0};
      // frame closes after the first digit
      cases[8]  = '{0, 14, {FAULT_PAT, ADDR_PAT, 8'h20, "4"}, 1'b1, 1'b1,
                    KIND_FAULT, 10'd0, 1'b0};
      cases[9]  = '{0, 0, 256'd0, 1'b1, 1'b1, KIND_NONE, 10'd0, 1'b0};
      // end symbol reuses the last start byte
      cases[10] = '{0, 10, {START_PAT, 8'h0A, 8'h1B, 8'h69, 8'h01}, 1'b0, 1'b1,
                    KIND_NONE, 10'd0, 1'b0};
      // partial start, then a full one
      cases[11] = '{0, 19, {8'hFF, 8'h1B, 8'h40, 8'h1C, START_PAT, FIRE_PAT, END_PAT},
                    1'b0, 1'b1, KIND_FIRE, 10'd0, 1'b0};
      // keywords and end symbol while hunting
      cases[12] = '{0, 10, {END_PAT, FIRE_PAT, 8'h00}, 1'b0, 1'b0,
                    KIND_NONE, 10'd0, 1'b0};
      // over-long frame: keyword cut by the clear, then one fully after it
      cases[13] = '{1014, 4, {FIRE_PAT}, 1'b1, 1'b1, KIND_NONE, 10'd0, 1'b0};
      cases[14] = '{1016, 16, {FAULT_PAT, ADDR_PAT, 8'h20, "807"}, 1'b1, 1'b1,
                    KIND_FAULT, 10'd807, 1'b1};
      // end symbol too soon after the clear is not a close: the frame runs on
      // to the row's own closing end symbol, which closes it
      cases[15] = '{1016, 5, {END_PAT}, 1'b1, 1'b0, KIND_NONE, 10'd0, 1'b0};
      cases[16] = '{0, 28, {FIRE_PAT, ADDR_PAT, 8'h20, "321", ADDR_PAT, 8'h20, "654"},
                    1'b1, 1'b1, KIND_FIRE, 10'd321, 1'b1};
      cases[17] = '{0, 22, {8'h00, FIRE_PAT, 8'hFF, FAULT_PAT, ADDR_PAT, 8'h3A, "095"},
                    1'b1, 1'b0, KIND_NONE, 10'd0, 1'b0};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_CASES; r++) begin
         seen_before = reports_seen;
         if (cases[r].framed)
            send_symbol(START_PAT, 6);
         repeat (cases[r].pad)
            send_byte(8'h00);
         for (int k = cases[r].len - 1; k >= 0; k--)
            send_byte(cases[r].body[8*k +: 8]);
         if (cases[r].framed)
            send_symbol(END_PAT, 5);
         // hold off until this frame's report is back
         wait_for_reports();
         if (cases[r].typed) begin
            if (reports_seen != seen_before + 1)
               report_mismatch($sformatf("case %0d: %0d reports", r,
                                         reports_seen - seen_before));
            else if (got_report !== alarm_report_type'{cases[r].kind, cases[r].part_id,
                                                        cases[r].id_valid})
               report_mismatch($sformatf("case %0d: got %0d/%0d/%0b", r, got_report.kind,
                                         got_report.part_id, got_report.id_valid));
         end
      end

      long_left = 2;
      framed_items = 0;
      frames_closed = 0;
      while (framed_items < 1000 || frames_closed < 40) begin
         if (framed_items < 333) begin
            send_idle_pct = 8;
            recv_idle_pct = 49;
         end else if (framed_items < 666) begin
            send_idle_pct = 49;
            recv_idle_pct = 8;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         repeat ($urandom_range(0, 2))
            send_byte(8'($urandom_range(0, 255)));
         // now and then break a start symbol by one bit
         if ($urandom_range(0, 11) == 0)
            send_symbol(START_PAT ^ (64'd1 << $urandom_range(0, 47)), 6);
         else
            send_symbol(START_PAT, 6);
         if (long_left > 0 && $urandom_range(0, 29) == 0) begin
            long_left--;
            repeat ($urandom_range(1000, 1030))
               send_byte(8'($urandom_range(0, 255)));
         end
         nseg = $urandom_range(0, 8);
         repeat (nseg) begin
            case ($urandom_range(0, 9))
               0, 1, 2: send_byte(8'($urandom_range(0, 255)));
               3:       send_symbol(FIRE_PAT, 4);
               4:       send_symbol(FAULT_PAT, 4);
               5:       send_symbol(CLEAR_PAT, 4);
               6, 7: begin
                  send_symbol(ADDR_PAT, 8);
                  send_byte(8'($urandom_range(0, 255)));
                  repeat (3) begin
                     if ($urandom_range(0, 9) == 0)
                        send_byte(8'($urandom_range(0, 255)));
                     else
                        send_byte(ASCII_ZERO + 8'($urandom_range(0, 9)));
                  end
               end
               8: begin
                  // leading part of the end symbol or the address marker
                  if ($urandom_range(0, 1) == 0) begin
                     cut = $urandom_range(1, 4);
                     send_symbol(END_PAT >> (8 * (5 - cut)), cut);
                  end else begin
                     cut = $urandom_range(1, 7);
                     send_symbol(ADDR_PAT >> (8 * (8 - cut)), cut);
                  end
               end
               default: send_symbol(START_PAT, 6);
            endcase
         end
         if ($urandom_range(0, 11) == 0)
            send_symbol(END_PAT ^ (64'd1 << $urandom_range(0, 39)), 5);
         else
            send_symbol(END_PAT, 5);
      end

      wait_for_reports();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_reports.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/arfp_pkg.sv
src/arfp_front.sv
src/arfp_queue.sv
src/arfp_back.sv
src/alarm_report_frame_parser.sv
sim/tb_top.sv
